[rtl/core/ibb_pkg.sv]
package ibb_pkg;

    localparam int PIX_W      = 8;
    localparam int WIN_BITS   = 8;   // history of each stage, 256 pixels
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 13;
    localparam int ACC_W      = 14;
    localparam int RAD_W      = 4;
    localparam int PASS_W     = 3;
    localparam int INV_W      = 17;
    localparam int PROD_W     = SUM_W + INV_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES = 1'b1;

    localparam logic [RAD_W-1:0]  RESET_RADIUS = 4'd5;
    localparam logic [PASS_W-1:0] RESET_PASSES = 3'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHK,
        S_INIT_RD,
        S_INIT_ACC,
        S_ADD_RD,
        S_ADD_ACC,
        S_SUB_RD,
        S_SUB_ACC,
        S_MUL,
        S_WR,
        S_EMIT_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_ROT_BACK
    } t_state;

    typedef enum logic [1:0] {
        ADDR_INIT,
        ADDR_ADD,
        ADDR_SUB,
        ADDR_EMIT
    } t_addr_sel;

    typedef struct packed {
        logic      init_clr;
        logic      init_acc;
        logic      load_sum;
        logic      add_acc;
        logic      sub_acc;
        logic      mul;
        logic      wr;
        logic      rotate;
        logic      emit_load;
        logic      close;
        t_addr_sel addr_sel;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic out_free;
        logic end_mode;
        logic short_line;
        logic at_p;
        logic run;
        logic x_zero;
        logic j_last;
        logic emit_ok;
        logic flush_more;
    } t_status;

    // Q16 reciprocal of 2r+1, rounded: (65536 + r) / (2r+1)
    function automatic logic [INV_W-1:0] f_inv(input logic [RAD_W-1:0] r);
        logic [INV_W-1:0] v;
        case (r)
            4'd1:    v = 17'd21845;
            4'd2:    v = 17'd13107;
            4'd3:    v = 17'd9362;
            4'd4:    v = 17'd7282;
            4'd5:    v = 17'd5958;
            4'd6:    v = 17'd5041;
            4'd7:    v = 17'd4369;
            4'd8:    v = 17'd3855;
            4'd9:    v = 17'd3449;
            4'd10:   v = 17'd3121;
            4'd11:   v = 17'd2849;
            4'd12:   v = 17'd2621;
            4'd13:   v = 17'd2427;
            4'd14:   v = 17'd2260;
            4'd15:   v = 17'd2114;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/ibb_pix_in_if.sv]
interface ibb_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [ibb_pkg::PIX_W-1:0] pixel_in;
    logic                      line_end;

    modport source (output valid, output pixel_in, output line_end, input ready);
    modport sink   (input valid, input pixel_in, input line_end, output ready);
endinterface

[rtl/core/ibb_pix_out_if.sv]
interface ibb_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [ibb_pkg::PIX_W-1:0] pixel_out;
    logic                      line_last;

    modport source (output valid, output pixel_out, output line_last, input ready);
    modport sink   (input valid, input pixel_out, input line_last, output ready);
endinterface

[rtl/core/ibb_ram.sv]
module ibb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/ibb_ctrl.sv]
module ibb_ctrl #(
    parameter int MAX_PASSES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ibb_pkg::t_status                i_status,
    output ibb_pkg::t_cmd                   o_cmd,
    output logic [$clog2(MAX_PASSES+1)-1:0] o_stage
);
    import ibb_pkg::*;

    localparam int SW = $clog2(MAX_PASSES + 1);

    t_state        r_state, n_state;
    logic [SW-1:0] r_stage, n_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_stage    = r_stage;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_status.pass || i_status.out_free;
                if (i_in_valid && o_in_ready && !i_status.pass) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.end_mode && i_status.short_line) begin
                    n_state = S_EMIT_CHK;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.at_p) begin
                    n_state = S_EMIT_CHK;
                end else if (i_status.run) begin
                    if (i_status.x_zero) begin
                        o_cmd.init_clr = 1'b1;
                        n_state        = S_INIT_RD;
                    end else begin
                        o_cmd.load_sum = 1'b1;
                        n_state        = S_ADD_RD;
                    end
                end else begin
                    o_cmd.rotate = 1'b1;
                    n_stage      = SW'(r_stage + 1'b1);
                end
            end
            S_INIT_RD: begin
                o_cmd.addr_sel = ADDR_INIT;
                n_state        = S_INIT_ACC;
            end
            S_INIT_ACC: begin
                o_cmd.init_acc = 1'b1;
                n_state        = i_status.j_last ? S_ADD_RD : S_INIT_RD;
            end
            S_ADD_RD: begin
                o_cmd.addr_sel = ADDR_ADD;
                n_state        = S_ADD_ACC;
            end
            S_ADD_ACC: begin
                o_cmd.add_acc = 1'b1;
                n_state       = S_SUB_RD;
            end
            S_SUB_RD: begin
                o_cmd.addr_sel = ADDR_SUB;
                n_state        = S_SUB_ACC;
            end
            S_SUB_ACC: begin
                o_cmd.sub_acc = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_CHK;
            end
            S_EMIT_CHK: begin
                if (i_status.end_mode) begin
                    if (i_status.flush_more) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        o_cmd.close = 1'b1;
                        n_stage     = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = i_status.emit_ok ? S_EMIT_RD : S_ROT_BACK;
                end
            end
            S_EMIT_RD: begin
                o_cmd.addr_sel = ADDR_EMIT;
                if (i_status.out_free) begin
                    n_state = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT: begin
                o_cmd.emit_load = 1'b1;
                n_state         = i_status.end_mode ? S_EMIT_CHK : S_ROT_BACK;
            end
            S_ROT_BACK: begin
                o_cmd.rotate = 1'b1;
                if (int'(r_stage) == MAX_PASSES) begin
                    n_stage = '0;
                    n_state = S_IDLE;
                end else begin
                    n_stage = SW'(r_stage + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
                n_stage = '0;
            end
        endcase
    end

    assign o_stage = r_stage;
endmodule

[rtl/core/ibb_dp.sv]
module ibb_dp #(
    parameter int MAX_RADIUS = 15,
    parameter int MAX_PASSES = 4,
    parameter int MAX_LINE   = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ibb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ibb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_accept,
    input  logic [ibb_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_last,
    input  ibb_pkg::t_cmd                      i_cmd,
    input  logic [$clog2(MAX_PASSES+1)-1:0]    i_stage,
    output ibb_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ibb_pkg::PIX_W-1:0]          o_out_pixel,
    output logic                               o_out_last
);
    import ibb_pkg::*;

    localparam int SW    = $clog2(MAX_PASSES + 1);
    localparam int NS    = MAX_PASSES + 1;
    localparam int AW    = SW + WIN_BITS;
    localparam int PW    = $clog2(MAX_LINE);
    localparam int LAG_W = $clog2((MAX_PASSES < 2 ? 2 : MAX_PASSES) * MAX_RADIUS + 1);

    // configuration
    logic [RAD_W-1:0]  r_cfg_r;
    logic [PASS_W-1:0] r_cfg_p;

    // line state
    logic              r_open;
    logic              r_end;
    logic [RAD_W-1:0]  r_r;
    logic [SW-1:0]     r_p;
    logic [LAG_W-1:0]  r_lag;
    logic [INV_W-1:0]  r_inv;
    logic [PW-1:0]     r_pos;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_emit;
    logic [CNT_W-1:0]  r_cnt [NS];
    logic [SUM_W-1:0]  r_sum [NS];

    // arithmetic
    logic [RAD_W-1:0]  r_j;
    logic [ACC_W-1:0]  r_w;
    logic [PROD_W-1:0] r_prod;

    // output register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_last;

    logic [RAD_W-1:0]  cfg_r_clamp, eff_r;
    logic [SW-1:0]     cfg_p_clamp, eff_p;
    logic              pass, out_free, new_line;
    logic [CNT_W-1:0]  x, r32, add_idx, sub_idx;
    logic              near_end;
    logic [PIX_W-1:0]  rdata, blur_pix;
    logic [PROD_W:0]   rnd;
    logic [ACC_W-1:0]  diff;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  wdata;

    assign cfg_r_clamp = (int'(r_cfg_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_cfg_r;
    assign cfg_p_clamp = (int'(r_cfg_p) > MAX_PASSES) ? SW'(MAX_PASSES) : SW'(r_cfg_p);
    assign new_line    = !r_open;
    assign eff_r       = r_open ? r_r : cfg_r_clamp;
    assign eff_p       = r_open ? r_p : cfg_p_clamp;
    assign pass        = (eff_r == '0) || (eff_p == '0);
    assign out_free    = !r_out_valid || i_out_ready;

    assign x        = r_cnt[1];
    assign r32      = CNT_W'(r_r);
    assign near_end = r_end && ((r_len - x) <= r32);
    assign add_idx  = near_end ? ((r_len << 1) - CNT_W'(1) - x - r32) : (x + r32);
    assign sub_idx  = (x <= r32) ? (r32 - x) : (x - r32 - CNT_W'(1));

    assign rnd      = {1'b0, r_prod} + (PROD_W+1)'(32768);
    assign blur_pix = (rnd[PROD_W:16] > (PROD_W-15)'(255)) ? 8'd255 : rnd[23:16];
    assign diff     = r_w - ACC_W'(rdata);

    always_comb begin
        o_status.pass       = pass;
        o_status.out_free   = out_free;
        o_status.end_mode   = r_end;
        o_status.short_line = r_pos < PW'({r_r, 1'b1});
        o_status.at_p       = i_stage == r_p;
        o_status.run        = r_end ? (x < r_len) : ((r_cnt[0] - x) > r32);
        o_status.x_zero     = x == '0;
        o_status.j_last     = r_j == r_r;
        o_status.emit_ok    = (r_emit != r_cnt[0])
                              && ((r_len - CNT_W'(1) - r_emit) >= CNT_W'(r_lag));
        o_status.flush_more = r_emit != r_len;
    end

    // shared history RAM: one 256-pixel window per stage
    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_INIT: raddr = {i_stage, {(WIN_BITS-RAD_W){1'b0}}, r_j};
            ADDR_ADD:  raddr = {i_stage, add_idx[WIN_BITS-1:0]};
            ADDR_SUB:  raddr = {i_stage, sub_idx[WIN_BITS-1:0]};
            ADDR_EMIT: raddr = {i_stage, r_emit[WIN_BITS-1:0]};
            default:   raddr = '0;
        endcase
        we = i_accept || i_cmd.wr;
        if (i_accept) begin
            waddr = {SW'(0), (r_open ? r_len[WIN_BITS-1:0] : {WIN_BITS{1'b0}})};
            wdata = i_pixel;
        end else begin
            waddr = {SW'(i_stage + 1'b1), x[WIN_BITS-1:0]};
            wdata = blur_pix;
        end
    end

    ibb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_r     <= RESET_RADIUS;
            r_cfg_p     <= RESET_PASSES;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS: r_cfg_r <= i_cfg_data;
                    CFG_PASSES: r_cfg_p <= i_cfg_data[PASS_W-1:0];
                    default:    r_cfg_r <= r_cfg_r;
                endcase
            end
            if (i_accept) begin
                r_open <= !(pass && i_last);
            end else if (i_cmd.close) begin
                r_open <= 1'b0;
            end
            if ((i_accept && pass) || i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line counters, sums and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_end <= i_last;
            if (new_line) begin
                r_r     <= eff_r;
                r_p     <= eff_p;
                r_lag   <= LAG_W'((eff_p < SW'(2) ? 2 : int'(eff_p)) * int'(eff_r));
                r_inv   <= f_inv(eff_r);
                r_pos   <= PW'(1);
                r_len   <= CNT_W'(1);
                r_emit  <= '0;
                for (int i = 0; i < NS; i++) begin
                    r_cnt[i] <= (i == 0) ? CNT_W'(1) : '0;
                    r_sum[i] <= '0;
                end
            end else begin
                if (int'(r_pos) < MAX_LINE - 1) begin
                    r_pos <= PW'(r_pos + 1'b1);
                end
                r_len    <= r_len + CNT_W'(1);
                r_cnt[0] <= r_cnt[0] + CNT_W'(1);
            end
        end
        if (i_cmd.rotate) begin
            for (int i = 0; i < NS; i++) begin
                r_cnt[i] <= r_cnt[(i + 1) % NS];
                r_sum[i] <= r_sum[(i + 1) % NS];
            end
        end
        if (i_cmd.wr) begin
            r_sum[0] <= r_w[SUM_W-1:0];
            r_cnt[1] <= x + CNT_W'(1);
        end
        if (i_cmd.emit_load) begin
            r_emit <= r_emit + CNT_W'(1);
        end

        if (i_cmd.init_clr) begin
            r_w <= '0;
            r_j <= '0;
        end else if (i_cmd.load_sum) begin
            r_w <= {1'b0, r_sum[0]};
        end else if (i_cmd.init_acc) begin
            // leading samples count twice: mirrored edge
            if (r_j == r_r) begin
                r_w <= r_w + ACC_W'(rdata);
            end else begin
                r_w <= r_w + ACC_W'({rdata, 1'b0});
                r_j <= RAD_W'(r_j + 1'b1);
            end
        end else if (i_cmd.add_acc) begin
            r_w <= r_w + ACC_W'(rdata);
        end else if (i_cmd.sub_acc) begin
            r_w <= (r_w >= ACC_W'(rdata)) ? {1'b0, diff[SUM_W-1:0]} : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_w[SUM_W-1:0] * r_inv;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_accept && pass) begin
            r_out_pixel <= i_pixel;
            r_out_last  <= i_last;
        end else if (i_cmd.emit_load) begin
            r_out_pixel <= rdata;
            r_out_last  <= r_end && ((r_emit + CNT_W'(1)) == r_len);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;
endmodule

[rtl/core/iterated_box_blur_line.sv]
// Channel  Dir  Transfer when       Payload
// i_pix    in   valid & ready       pixel_in[7:0], line_end
// o_pix    out  valid & ready       pixel_out[7:0], line_last
// i_cfg    in   i_cfg_we            i_cfg_idx (0 radius, 1 passes), i_cfg_data[3:0]
//
// Pass-through (radius or passes zero): one pixel per cycle through the output register
// while the output is not stalled. Blur: each pixel is carried through the stages in
// turn (add read, subtract read, multiply, write back), after a mirrored fill when a
// stage makes its first sample, plus a result read when one is ready; every step uses
// the history RAM's one read port, as do the line-end flush's stage samples and pixels.
// Reset is synchronous, active low; config regs go to radius 5, passes 2, no line open.
// A stalled output holds the controller only when it has another result to hand over.
module iterated_box_blur_line #(
    parameter int MAX_RADIUS = 15,
    parameter int MAX_PASSES = 4,
    parameter int MAX_LINE   = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ibb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ibb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ibb_pix_in_if.sink                     i_pix,
    ibb_pix_out_if.source                  o_pix
);
    import ibb_pkg::*;

    localparam int SW = $clog2(MAX_PASSES + 1);

    t_cmd          cmd;
    t_status       status;
    logic [SW-1:0] stage;
    logic          in_ready;
    logic          accept;

    // input transfer; ready drops while the controller walks the stages
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    ibb_ctrl #(
        .MAX_PASSES (MAX_PASSES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_stage    (stage)
    );

    // running sums, stage counters, history RAM and output register
    ibb_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_PASSES (MAX_PASSES),
        .MAX_LINE   (MAX_LINE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pix.pixel_in),
        .i_last      (i_pix.line_end),
        .i_cmd       (cmd),
        .i_stage     (stage),
        .o_status    (status),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_out_pixel (o_pix.pixel_out),
        .o_out_last  (o_pix.line_last)
    );
endmodule

[rtl/core/ibb_checker.sv]
module ibb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_pixel,
    input logic       i_out_last
);
    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // once a line's last result is taken, valid drops at once unless a new pixel was accepted alongside it
    a_line_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last && !(i_in_valid && i_in_ready)
        |=> !i_out_valid)
        else $error("result after line end without new input");
endmodule

bind iterated_box_blur_line ibb_checker u_ibb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_last  (o_pix.line_last)
);
